FILE: rtl/tgou_pkg.sv
// ----------------------------------------------------------------------------
// tgou_pkg: toroidal grid origin update, shared definitions
// Field widths, range limits, status codes, item structs and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tgou_pkg;

	localparam int unsigned PosW     = 32;
	localparam int unsigned DimW     = 11;
	localparam int unsigned HoffW    = 12;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 12;
	localparam int unsigned NumAxes  = 3;

	localparam int unsigned DimMax     = 1024;
	localparam int unsigned DimMin     = 2;
	localparam int unsigned WrapOffset = 65536;

	// partial products of the slab volume
	localparam int unsigned P1W  = 2 * DimW - 1;
	localparam int unsigned P2W  = 3 * DimW - 2;
	localparam int unsigned VolW = P2W + 1;

	localparam longint RangeLoL = -longint'(WrapOffset);
	localparam longint RangeHiL = (longint'(1) << (PosW - 1)) - longint'(WrapOffset);
	localparam logic signed [PosW:0] RangeLo = (PosW + 1)'(RangeLoL);
	localparam logic signed [PosW:0] RangeHi = (PosW + 1)'(RangeHiL);

	localparam logic [PosW-1:0] InvalidMark = 32'h00FF_FFFF;

	localparam logic [DimW-1:0]  XzDimRst = 11'd128;
	localparam logic [DimW-1:0]  YDimRst  = 11'd64;
	localparam logic [DimW-1:0]  ThrRst   = 11'd4;
	localparam logic [HoffW-1:0] HoffRst  = 12'd0;

	localparam logic [1:0] AxisX = 2'd0;
	localparam logic [1:0] AxisY = 2'd1;
	localparam logic [1:0] AxisZ = 2'd2;

	typedef enum logic [1:0] {
		STAT_NONE    = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_PARTIAL = 2'd2,
		STAT_OOR     = 2'd3
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_XZ_DIM     = 2'd0,
		REG_Y_DIM      = 2'd1,
		REG_MOVE_THR   = 2'd2,
		REG_HEIGHT_OFF = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                   command;
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [PosW-1:0] pos_z;
		logic                   dominant_only;
	} req_item_t;

	typedef struct packed {
		status_t                status;
		logic signed [PosW-1:0] corner_x;
		logic signed [PosW-1:0] corner_y;
		logic signed [PosW-1:0] corner_z;
		logic [DimW-1:0]        extent_x;
		logic [DimW-1:0]        extent_y;
		logic [DimW-1:0]        extent_z;
		logic                   last;
	} rsp_item_t;

	typedef enum logic [3:0] {
		OP_NOP         = 4'd0,
		OP_LOAD        = 4'd1,
		OP_RANGE       = 4'd2,
		OP_DIFF        = 4'd3,
		OP_DECIDE      = 4'd4,
		OP_CORNER      = 4'd5,
		OP_MUL1        = 4'd6,
		OP_MUL2        = 4'd7,
		OP_ACC         = 4'd8,
		OP_VCHK        = 4'd9,
		OP_EMIT_SINGLE = 4'd10,
		OP_EMIT_SLAB   = 4'd11
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic               partial;
		logic               promote;
		logic               slot_free;
		logic [NumAxes-1:0] moved;
		logic               slab_last;
	} dp_stat_t;

endpackage

FILE: rtl/tgou_dp.sv
// ----------------------------------------------------------------------------
// tgou_dp: origin update datapath
// Config registers, grid origin, movement and decision logic, slab corner
// generation, shared volume multipliers and the result output register.
// ----------------------------------------------------------------------------
module tgou_dp import tgou_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  req_item_t           req_item,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output rsp_item_t           rsp_item
);

	function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] d);
		if (d < DimW'(DimMin)) begin
			return DimW'(DimMin);
		end else if (d > DimW'(DimMax)) begin
			return DimW'(DimMax);
		end
		return d;
	endfunction

	logic [DimW-1:0]         xz_dim_q, y_dim_q, thr_q;
	logic [HoffW-1:0]        hoff_q;
	logic [DimW-1:0]         xz_sat, y_sat;
	logic [DimW-2:0]         half [NumAxes];
	logic [DimW-1:0]         ext_full [NumAxes];
	logic [P1W-1:0]          xz_sq_q;
	logic [P2W-1:0]          max_vol_q;
	logic [2*DimW-1:0]       xz_sq_full;
	logic [P1W+DimW-1:0]     max_vol_full;

	logic                    cmd_q, onedir_q;
	logic signed [PosW-1:0]  pos_q [NumAxes];
	logic signed [PosW-1:0]  np_q [NumAxes];
	logic                    oor_q, eq_q;
	logic signed [PosW-1:0]  origin_q [NumAxes];
	logic signed [PosW:0]    mv_q [NumAxes];
	logic [PosW:0]           am_q [NumAxes];
	logic signed [DimW:0]    mvs_q [NumAxes];
	logic signed [PosW-1:0]  nlo_q [NumAxes];
	logic signed [PosW-1:0]  phi_q [NumAxes];
	logic [P1W-1:0]          p1_q;
	logic [P2W-1:0]          p2_q;
	logic [VolW-1:0]         vol_q;
	status_t                 stat_q;
	logic                    rsp_valid_q;
	rsp_item_t               rsp_q;

	logic [NumAxes-1:0]      in_rng;
	logic signed [PosW-1:0]  hoff_ext;
	logic signed [PosW:0]    mv_c [NumAxes];
	logic [PosW:0]           am_c [NumAxes];
	logic                    eq_c;
	logic [PosW:0]           xz_w, y_w, thr_w;
	logic                    big, slow, dom_x, dom_y, partial_c;
	logic [NumAxes-1:0]      keep;
	logic signed [DimW+1:0]  lo_off [NumAxes];
	logic signed [PosW-1:0]  nlo_c [NumAxes];
	logic signed [PosW-1:0]  phi_c [NumAxes];
	logic signed [PosW-1:0]  org_new [NumAxes];
	logic [DimW-1:0]         mvs_abs [NumAxes];
	logic [NumAxes-1:0]      moved;
	logic [DimW-1:0]         amk, eb, ec;
	logic [2*DimW-1:0]       p1_full;
	logic [P1W+DimW-1:0]     p2_full;
	logic                    promote, slab_last, slot_free, load;
	logic signed [PosW-1:0]  corner_c [NumAxes];
	logic [DimW-1:0]         ext_c [NumAxes];
	rsp_item_t               rsp_d;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xz_dim_q <= XzDimRst;
			y_dim_q  <= YDimRst;
			thr_q    <= ThrRst;
			hoff_q   <= HoffRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_XZ_DIM:     xz_dim_q <= cfg_data[DimW-1:0];
				REG_Y_DIM:      y_dim_q  <= cfg_data[DimW-1:0];
				REG_MOVE_THR:   thr_q    <= cfg_data[DimW-1:0];
				REG_HEIGHT_OFF: hoff_q   <= cfg_data[HoffW-1:0];
			endcase
		end
	end

	assign xz_sat = sat_dim(xz_dim_q);
	assign y_sat  = sat_dim(y_dim_q);
	assign half[0] = xz_sat[DimW-1:1];
	assign half[1] = y_sat[DimW-1:1];
	assign half[2] = xz_sat[DimW-1:1];

	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			ext_full[i] = {half[i], 1'b0};
		end
	end

	// grid volume follows the config registers through the registers xz_sq_q and max_vol_q
	assign xz_sq_full   = {{DimW{1'b0}}, xz_sat} * {{DimW{1'b0}}, xz_sat};
	assign max_vol_full = {{DimW{1'b0}}, xz_sq_q} * {{P1W{1'b0}}, y_sat};

	always_ff @(posedge clk) begin
		xz_sq_q   <= xz_sq_full[P1W-1:0];
		max_vol_q <= max_vol_full[P2W-1:0];
	end

	// ---------------------------------------------------------- evaluation
	assign hoff_ext = {{(PosW-HoffW){hoff_q[HoffW-1]}}, hoff_q};

	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			in_rng[i] = ($signed({pos_q[i][PosW-1], pos_q[i]}) >= RangeLo) &&
				($signed({pos_q[i][PosW-1], pos_q[i]}) <= RangeHi);
			mv_c[i] = $signed({np_q[i][PosW-1], np_q[i]}) -
				$signed({origin_q[i][PosW-1], origin_q[i]});
			am_c[i] = mv_c[i][PosW] ? $unsigned(-mv_c[i]) : $unsigned(mv_c[i]);
		end
	end

	assign eq_c = (np_q[0] == origin_q[0]) && (np_q[1] == origin_q[1]) &&
		(np_q[2] == origin_q[2]);

	assign xz_w  = {{(PosW+1-DimW){1'b0}}, xz_sat};
	assign y_w   = {{(PosW+1-DimW){1'b0}}, y_sat};
	assign thr_w = {{(PosW+1-DimW){1'b0}}, thr_q};

	assign big   = (am_q[0] >= xz_w) || (am_q[2] >= xz_w) || (am_q[1] > y_w);
	assign slow  = (am_q[0] < thr_w) && (am_q[1] < thr_w) && (am_q[2] < thr_w);
	assign dom_x = (am_q[0] >= am_q[1]) && (am_q[0] >= am_q[2]);
	assign dom_y = (am_q[1] >= am_q[0]) && (am_q[1] >= am_q[2]);
	assign keep  = !onedir_q ? 3'b111 : dom_x ? 3'b001 : dom_y ? 3'b010 : 3'b100;
	assign partial_c = !cmd_q && !oor_q && !eq_q && !big && !slow;

	// ---------------------------------------------------------- slab corners
	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			lo_off[i]  = $signed({mvs_q[i][DimW], mvs_q[i]}) - $signed({3'b000, half[i]});
			nlo_c[i]   = origin_q[i] + {{(PosW-DimW-2){lo_off[i][DimW+1]}}, lo_off[i]};
			phi_c[i]   = origin_q[i] + {{(PosW-DimW+1){1'b0}}, half[i]};
			org_new[i] = origin_q[i] + {{(PosW-DimW-1){mvs_q[i][DimW]}}, mvs_q[i]};
			mvs_abs[i] = mvs_q[i][DimW] ? DimW'(-mvs_q[i]) : mvs_q[i][DimW-1:0];
			moved[i]   = (mvs_q[i] != '0);
		end
	end

	// ---------------------------------------------------------- slab volume
	always_comb begin
		amk = mvs_abs[cmd.axis];
		unique case (cmd.axis)
			AxisX: begin
				eb = ext_full[1];
				ec = ext_full[2];
			end
			AxisY: begin
				eb = ext_full[0];
				ec = ext_full[2];
			end
			AxisZ: begin
				eb = ext_full[0];
				ec = ext_full[1];
			end
			default: begin
				eb = '0;
				ec = '0;
			end
		endcase
	end

	assign p1_full = {{DimW{1'b0}}, amk} * {{DimW{1'b0}}, eb};
	assign p2_full = {{DimW{1'b0}}, p1_q} * {{P1W{1'b0}}, ec};
	assign promote = (vol_q >= {1'b0, max_vol_q});

	// ---------------------------------------------------------- result build
	assign slab_last = (cmd.axis == AxisX) ? !(moved[1] || moved[2]) :
		(cmd.axis == AxisY) ? !moved[2] : 1'b1;

	always_comb begin
		for (int i = 0; i < NumAxes; i++) begin
			corner_c[i] = ((2'(i) == cmd.axis) && !mvs_q[i][DimW]) ? phi_q[i] : nlo_q[i];
			ext_c[i]    = (2'(i) == cmd.axis) ? mvs_abs[i] : ext_full[i];
		end
		rsp_d = '0;
		rsp_d.last = 1'b1;
		if (cmd.op == OP_EMIT_SLAB) begin
			rsp_d.status   = STAT_PARTIAL;
			rsp_d.corner_x = corner_c[0];
			rsp_d.corner_y = corner_c[1];
			rsp_d.corner_z = corner_c[2];
			rsp_d.extent_x = ext_c[0];
			rsp_d.extent_y = ext_c[1];
			rsp_d.extent_z = ext_c[2];
			rsp_d.last     = slab_last;
		end else begin
			rsp_d.status = stat_q;
		end
	end

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign load = (cmd.op == OP_EMIT_SINGLE) ||
		((cmd.op == OP_EMIT_SLAB) && moved[cmd.axis]);

	// ---------------------------------------------------------- work registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				cmd_q    <= req_item.command;
				onedir_q <= req_item.dominant_only;
				pos_q[0] <= req_item.pos_x;
				pos_q[1] <= req_item.pos_y;
				pos_q[2] <= req_item.pos_z;
			end
			OP_RANGE: begin
				oor_q   <= !(&in_rng);
				np_q[0] <= pos_q[0];
				np_q[1] <= pos_q[1] + hoff_ext;
				np_q[2] <= pos_q[2];
			end
			OP_DIFF: begin
				eq_q <= eq_c;
				for (int i = 0; i < NumAxes; i++) begin
					mv_q[i] <= mv_c[i];
					am_q[i] <= am_c[i];
				end
			end
			OP_DECIDE: begin
				priority if (cmd_q) begin
					stat_q <= STAT_NONE;
				end else if (oor_q) begin
					stat_q <= STAT_OOR;
				end else if (eq_q) begin
					stat_q <= STAT_NONE;
				end else if (big) begin
					stat_q <= STAT_FULL;
				end else begin
					stat_q <= STAT_NONE;
				end
				for (int i = 0; i < NumAxes; i++) begin
					mvs_q[i] <= keep[i] ? mv_q[i][DimW:0] : '0;
				end
			end
			OP_CORNER: begin
				vol_q <= '0;
				for (int i = 0; i < NumAxes; i++) begin
					nlo_q[i] <= nlo_c[i];
					phi_q[i] <= phi_c[i];
				end
			end
			OP_MUL1: p1_q <= p1_full[P1W-1:0];
			OP_MUL2: p2_q <= p2_full[P2W-1:0];
			OP_ACC:  vol_q <= vol_q + {1'b0, p2_q};
			OP_VCHK: stat_q <= promote ? STAT_FULL : STAT_PARTIAL;
			default: begin
			end
		endcase
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	// origin: invalidate and full update at the decision, slab moves afterwards
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumAxes; i++) begin
				origin_q[i] <= InvalidMark;
			end
		end else if (cmd.op == OP_DECIDE) begin
			if (cmd_q) begin
				for (int i = 0; i < NumAxes; i++) begin
					origin_q[i] <= InvalidMark;
				end
			end else if (!oor_q && !eq_q && big) begin
				for (int i = 0; i < NumAxes; i++) begin
					origin_q[i] <= np_q[i];
				end
			end
		end else if (cmd.op == OP_CORNER) begin
			for (int i = 0; i < NumAxes; i++) begin
				origin_q[i] <= org_new[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	assign stat.partial   = partial_c;
	assign stat.promote   = promote;
	assign stat.slot_free = slot_free;
	assign stat.moved     = moved;
	assign stat.slab_last = slab_last;

endmodule

FILE: rtl/tgou_ctrl.sv
// ----------------------------------------------------------------------------
// tgou_ctrl: origin update sequencer
// Walks items through range check, movement, decision, slab volume (partial
// moves) and emission, one datapath command per cycle but for output stalls.
// ----------------------------------------------------------------------------
module tgou_ctrl import tgou_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_RANGE  = 11'b000_0000_0010,
		ST_DIFF   = 11'b000_0000_0100,
		ST_DECIDE = 11'b000_0000_1000,
		ST_CORNER = 11'b000_0001_0000,
		ST_MUL1   = 11'b000_0010_0000,
		ST_MUL2   = 11'b000_0100_0000,
		ST_ACC    = 11'b000_1000_0000,
		ST_VCHK   = 11'b001_0000_0000,
		ST_SINGLE = 11'b010_0000_0000,
		ST_SLAB   = 11'b100_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] axis_q, axis_d;

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd.op   = OP_NOP;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_RANGE;
				end
			end
			ST_RANGE: begin
				cmd.op  = OP_RANGE;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = stat.partial ? ST_CORNER : ST_SINGLE;
			end
			ST_CORNER: begin
				cmd.op  = OP_CORNER;
				axis_d  = AxisX;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.op  = OP_MUL2;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op = OP_ACC;
				if (axis_q == AxisZ) begin
					state_d = ST_VCHK;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_MUL1;
				end
			end
			ST_VCHK: begin
				cmd.op  = OP_VCHK;
				axis_d  = AxisX;
				state_d = stat.promote ? ST_SINGLE : ST_SLAB;
			end
			ST_SINGLE: begin
				if (stat.slot_free) begin
					cmd.op  = OP_EMIT_SINGLE;
					state_d = ST_IDLE;
				end
			end
			ST_SLAB: begin
				// axes that did not move are passed over without a result
				if (!stat.moved[axis_q]) begin
					axis_d  = axis_q + 2'd1;
					state_d = (axis_q == AxisZ) ? ST_IDLE : ST_SLAB;
				end else if (stat.slot_free) begin
					cmd.op  = OP_EMIT_SLAB;
					axis_d  = axis_q + 2'd1;
					state_d = stat.slab_last ? ST_IDLE : ST_SLAB;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AxisX;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	assign req_stall = (state_q != ST_IDLE);

endmodule

FILE: rtl/toroidal_grid_origin_update_top.sv
// Results: a single-result item (none, full, out of range, invalidate) or a promoted full
//   update is registered at the output as one result item; slab regions follow each other.
// Flow: a new item is taken only once the previous one has emitted its last result, and an
//   output stall holds the block busy; only axes that moved yield a slab region, and
//   the slab volume runs through multipliers shared by all axes, three steps per axis.
// Reset: origin set to the invalid marker 0xffffff, config registers to their defaults.
// ----------------------------------------------------------------------------
// toroidal_grid_origin_update_top: toroidal grid origin tracker
// Keeps the voxel grid origin and answers each position item with none, full
// update, out of range, or one to three slab regions to refresh.
// ----------------------------------------------------------------------------
module toroidal_grid_origin_update_top import tgou_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_item_t           req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_item_t           rsp_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tgou_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tgou_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_item  (req_item),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

	// an accepted item keeps the block busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item accepted but block not busy next cycle");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.status != STAT_PARTIAL) |-> rsp_item.last)
		else $error("non-region result without last");

	a_slab_extent: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.status == STAT_PARTIAL) |->
		(rsp_item.extent_x != '0 && rsp_item.extent_y != '0 && rsp_item.extent_z != '0))
		else $error("slab region with empty extent");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the toroidal grid origin tracker
// Drives position and invalidate items through the valid/stall channels, keeps
// its own model of the grid origin and the registers, and checks each result
// item field by field in arrival order. Register settings are swept between
// phases while the block is idle. Sender gaps and receiver stalls vary per
// phase, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
	import tgou_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     DrainCycles = 30;
	localparam int     HoldCycles  = 400;
	localparam longint Marker      = longint'(InvalidMark);
	localparam int     ReqW        = $bits(req_item_t);

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	req_item_t           req_item;
	logic                rsp_valid;
	logic                rsp_stall;
	rsp_item_t           rsp_item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// model of the block
	logic [DimW-1:0]         cur_xz;
	logic [DimW-1:0]         cur_y;
	logic [DimW-1:0]         cur_thr;
	logic signed [HoffW-1:0] cur_hoff;
	longint                  origin[3];
	rsp_item_t               expected_rsp_q[$];

	int n_errors;
	int n_items;
	int n_results;
	int n_settings;
	int status_count[4];
	int src_idle_pct;
	int sink_stall_pct;
	int hold_req_id;

	toroidal_grid_origin_update_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint wrap32(input longint v);
		logic signed [31:0] t;
		t = v[31:0];
		return longint'(t);
	endfunction

	function automatic longint sat_dim(input longint d);
		if (d < longint'(DimMin))
			return longint'(DimMin);
		if (d > longint'(DimMax))
			return longint'(DimMax);
		return d;
	endfunction

	function automatic void push_single(input status_t s);
		rsp_item_t r;
		r = '0;
		r.status = s;
		r.last = 1'b1;
		expected_rsp_q.insert(expected_rsp_q.size(), r);
	endfunction

	// works out the result items of one accepted item and moves the origin
	function automatic void predict_origin_update(input req_item_t it);
		longint np[3], org[3], mv[3], am[3], dim[3], hlf[3];
		longint plo[3], phi[3], nlo[3], nhi[3], lo[3], hi[3], ext[3];
		longint xz, yd, mx, lim;
		longint unsigned vol, maxvol;
		rsp_item_t slab[$];
		rsp_item_t r;
		if (it.command) begin
			origin = '{Marker, Marker, Marker};
			push_single(STAT_NONE);
			return;
		end
		np[0] = it.pos_x;
		np[1] = it.pos_y;
		np[2] = it.pos_z;
		lim = (longint'(1) << (PosW - 1)) - longint'(WrapOffset);
		for (int a = 0; a < 3; a++) begin
			if (np[a] < -longint'(WrapOffset) || np[a] > lim) begin
				push_single(STAT_OOR);
				return;
			end
		end
		np[1] = wrap32(np[1] + longint'(cur_hoff));
		org = origin;
		if (np[0] == org[0] && np[1] == org[1] && np[2] == org[2]) begin
			push_single(STAT_NONE);
			return;
		end
		xz = sat_dim(longint'(cur_xz));
		yd = sat_dim(longint'(cur_y));
		for (int a = 0; a < 3; a++) begin
			mv[a] = np[a] - org[a];
			am[a] = (mv[a] < 0) ? -mv[a] : mv[a];
		end
		if (((am[0] > am[2]) ? am[0] : am[2]) >= xz || am[1] > yd) begin
			origin = np;
			push_single(STAT_FULL);
			return;
		end
		mx = am[0];
		if (am[1] > mx)
			mx = am[1];
		if (am[2] > mx)
			mx = am[2];
		if (mx < longint'(cur_thr)) begin
			push_single(STAT_NONE);
			return;
		end
		// keep the dominant axis only; ties go to x, then y
		if (it.dominant_only) begin
			if (am[0] >= am[1] && am[0] >= am[2]) begin
				mv[1] = 0;
				mv[2] = 0;
			end else if (am[1] >= am[0] && am[1] >= am[2]) begin
				mv[0] = 0;
				mv[2] = 0;
			end else begin
				mv[0] = 0;
				mv[1] = 0;
			end
		end
		dim = '{xz, yd, xz};
		for (int a = 0; a < 3; a++) begin
			hlf[a] = dim[a] / 2;
			plo[a] = org[a] - hlf[a];
			phi[a] = org[a] + hlf[a];
			nlo[a] = plo[a] + mv[a];
			nhi[a] = phi[a] + mv[a];
			origin[a] = wrap32(org[a] + mv[a]);
		end
		vol = 0;
		for (int a = 0; a < 3; a++) begin
			if (mv[a] != 0) begin
				lo = nlo;
				hi = nhi;
				if (mv[a] > 0)
					lo[a] = phi[a];
				else
					hi[a] = plo[a];
				for (int i = 0; i < 3; i++)
					ext[i] = hi[i] - lo[i];
				r = '0;
				r.status = STAT_PARTIAL;
				r.corner_x = 32'(lo[0]);
				r.corner_y = 32'(lo[1]);
				r.corner_z = 32'(lo[2]);
				r.extent_x = DimW'(ext[0]);
				r.extent_y = DimW'(ext[1]);
				r.extent_z = DimW'(ext[2]);
				vol += longint'(ext[0] * ext[1] * ext[2]);
				slab.insert(slab.size(), r);
			end
		end
		maxvol = xz * xz * yd;
		if (slab.size() == 0 || vol >= maxvol) begin
			push_single(STAT_FULL);
			return;
		end
		slab[slab.size() - 1].last = 1'b1;
		foreach (slab[i])
			expected_rsp_q.insert(expected_rsp_q.size(), slab[i]);
	endfunction

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_results++;
			if (expected_rsp_q.size() == 0) begin
				$error("result item with nothing expected: status %0d", rsp_item.status);
				n_errors++;
			end else begin
				want = expected_rsp_q.pop_front();
				status_count[want.status]++;
				check_field("status", longint'(want.status), longint'(rsp_item.status));
				check_field("corner_x", want.corner_x, rsp_item.corner_x);
				check_field("corner_y", want.corner_y, rsp_item.corner_y);
				check_field("corner_z", want.corner_z, rsp_item.corner_z);
				check_field("extent_x", want.extent_x, rsp_item.extent_x);
				check_field("extent_y", want.extent_y, rsp_item.extent_y);
				check_field("extent_z", want.extent_z, rsp_item.extent_z);
				check_field("last", want.last, rsp_item.last);
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : rsp_sink
		int hold_left;
		int hold_ack;
		hold_left = 0;
		hold_ack = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ack != hold_req_id) begin
				hold_ack = hold_req_id;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
			end
		end
	end

	// returns at the rising edge that accepted the item
	task automatic send_item(input req_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_item <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		n_items++;
		predict_origin_update(it);
	endtask

	function automatic req_item_t item_at_offset(input longint dx, input longint dy,
			input longint dz, input logic od);
		req_item_t it;
		it.command = 1'b0;
		it.dominant_only = od;
		it.pos_x = 32'(origin[0] + dx);
		it.pos_y = 32'(origin[1] + dy - longint'(cur_hoff));
		it.pos_z = 32'(origin[2] + dz);
		return it;
	endfunction

	task automatic send_move(input longint dx, input longint dy, input longint dz,
			input logic od);
		send_item(item_at_offset(dx, dy, dz, od));
	endtask

	task automatic send_pos(input int x, input int y, input int z);
		req_item_t it;
		it.command = 1'b0;
		it.dominant_only = 1'b0;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		send_item(it);
	endtask

	function automatic longint rand_delta(input longint d);
		int unsigned pick;
		longint m;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return 0;
		if (pick == 3)
			m = $urandom_range(0, cur_thr);
		else if (pick == 9)
			m = d + $urandom_range(0, 3);
		else
			m = $urandom_range(0, int'(d));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic req_item_t random_item();
		req_item_t it;
		int unsigned kind;
		longint xz, yd;
		xz = sat_dim(longint'(cur_xz));
		yd = sat_dim(longint'(cur_y));
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			it = ReqW'({$urandom(), $urandom(), $urandom(), $urandom()});
			it.command = 1'b1;
		end else if (kind < 14) begin
			it = ReqW'({$urandom(), $urandom(), $urandom(), $urandom()});
			it.command = 1'b0;
		end else if (kind < 20) begin
			it.command = 1'b0;
			it.dominant_only = $urandom_range(0, 1);
			it.pos_x = 32'($urandom_range(0, 32'h7FFF_FFFF)) - 32'(WrapOffset);
			it.pos_y = 32'($urandom_range(0, 32'h7FFF_FFFF)) - 32'(WrapOffset);
			it.pos_z = 32'($urandom_range(0, 32'h7FFF_FFFF)) - 32'(WrapOffset);
		end else if (kind < 25) begin
			it = item_at_offset(0, 0, 0, $urandom_range(0, 1));
		end else begin
			it = item_at_offset(rand_delta(xz - 1), rand_delta(yd), rand_delta(xz - 1),
				$urandom_range(0, 1));
		end
		return it;
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_item(random_item());
	endtask

	// called at a rising edge so the receiver never reads a half-updated setting
	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_XZ_DIM:     cur_xz = value[DimW-1:0];
			REG_Y_DIM:      cur_y = value[DimW-1:0];
			REG_MOVE_THR:   cur_thr = value[DimW-1:0];
			REG_HEIGHT_OFF: cur_hoff = value[HoffW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [CfgDataW-1:0] xz, input logic [CfgDataW-1:0] yd,
			input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] hoff);
		write_reg(REG_XZ_DIM, xz);
		write_reg(REG_Y_DIM, yd);
		write_reg(REG_MOVE_THR, thr);
		write_reg(REG_HEIGHT_OFF, hoff);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic test_directed();
		req_item_t it;
		set_idling(0, 0);
		it = ReqW'({$urandom(), $urandom(), $urandom(), $urandom()});
		it.command = 1'b1;
		send_item(it);
		send_move(0, 0, 0, 1'b0);           // position on the marker itself
		send_move(3, 0, -2, 1'b0);          // under the movement threshold
		send_move(5, 0, 0, 1'b0);
		send_move(-7, 0, 0, 1'b0);
		send_move(0, 10, 0, 1'b0);
		send_move(0, -12, 0, 1'b0);
		send_move(0, 0, 20, 1'b0);
		send_move(0, 0, -20, 1'b0);
		send_move(6, -6, 9, 1'b0);          // three slabs
		send_move(8, 8, 3, 1'b1);           // tie x/y keeps x
		send_move(2, 9, -9, 1'b1);          // tie y/z keeps y
		send_move(-4, 2, -30, 1'b1);
		send_move(60, 40, 10, 1'b0);        // slab volume reaches the grid volume
		send_move(127, 0, 0, 1'b0);
		send_move(-128, 0, 0, 1'b0);
		send_move(0, 64, 0, 1'b0);
		send_move(0, 0, 65, 1'b0);
		send_move(0, -65, 0, 1'b0);
		send_pos(-65537, 0, 0);
		send_pos(0, 32'sh7FFF_0001, 0);
		send_pos(0, 0, 32'sh8000_0000);
		send_pos(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_pos(-65536, -65536, -65536);
		send_pos(32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000);
		it.command = 1'b1;
		send_item(it);
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		send_random(1);
		hold_req_id++;
		send_random(29);
	endtask

	task automatic test_random_traffic();
		set_idling(0, 0);
		send_random(55);
		set_idling(46, 0);
		send_random(55);
		set_idling(0, 46);
		send_random(55);
		set_idling(37, 37);
		send_random(55);
	endtask

	task automatic test_register_settings();
		drain();
		set_idling(20, 20);
		apply_config(12'd2, 12'd2, 12'd0, 12'hC00);        // smallest grid, offset -1024
		send_random(20);
		drain();
		apply_config(12'd1024, 12'd1024, 12'd1024, 12'd1024);
		send_random(20);
		drain();
		apply_config(12'd127, 12'd33, 12'd3, 12'd5);        // odd dimensions
		send_random(20);
		drain();
		apply_config(12'd0, 12'hFFF, 12'd1, 12'h7FF);       // dimensions clamp
		send_random(20);
		drain();
		apply_config(12'd1, 12'd3, 12'd2047, 12'h800);
		send_random(20);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_errors = 0;
		n_items = 0;
		n_results = 0;
		n_settings = 1;
		status_count = '{0, 0, 0, 0};
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req_id = 0;
		cur_xz = XzDimRst;
		cur_y = YDimRst;
		cur_thr = ThrRst;
		cur_hoff = HoffRst;
		origin = '{Marker, Marker, Marker};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_traffic();
		test_register_settings();
		drain();

		$display("Sent %0d items under %0d register settings, checked %0d result items:",
			n_items, n_settings, n_results);
		$display("  %0d none, %0d full, %0d slab, %0d out of range",
			status_count[STAT_NONE], status_count[STAT_FULL],
			status_count[STAT_PARTIAL], status_count[STAT_OOR]);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
